[design/dltq_pkg.sv]
// Package for the delta list timer queue: capacity, command and status codes,
// cell entry type and cell control. Used by dltq_cell and delta_list_timer_queue.
package dltq_pkg;

	localparam int CAP = 256;
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int STEP_W = $clog2(CAP);

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_SET    = 3'd1;
	localparam logic [2:0] CMD_CANCEL = 3'd2;
	localparam logic [2:0] CMD_POLL   = 3'd3;
	localparam logic [2:0] CMD_POP    = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic        valid;
		logic [31:0] ident;
		logic [31:0] delta;
		logic [31:0] h1;
		logic [31:0] h2;
		logic [63:0] u1;
		logic [63:0] u2;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TICK,
		OP_MATCH,
		OP_MATCH_CARRY,
		OP_CARRY_HEAD,
		OP_PROP,
		OP_SHIFT_IN,
		OP_STEP_SET,
		OP_STEP_REM,
		OP_CLEAR_LAST
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] key;
		logic        fresh;
	} cell_ctl_t;

endpackage

[design/dltq_cell.sv]
// One cell of the ordered timer chain: holds one entry plus carry and hit flags,
// swaps with its right neighbor to move a carried entry. Uses dltq_pkg.
module dltq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dltq_pkg::cell_ctl_t ctl,
	input  logic                has_left,
	input  logic                has_right,
	input  dltq_pkg::entry_t    left_ent,
	input  dltq_pkg::entry_t    right_ent,
	input  logic                left_swap,
	input  logic                left_stop,
	input  logic                left_hit,
	output dltq_pkg::entry_t    ent,
	output logic                carry,
	output logic                hit,
	output logic                swap,
	output logic                stop
);

	dltq_pkg::entry_t ent_q, ent_d;
	logic carry_q, carry_d, hit_q, hit_d;
	logic step_set, step_rem;
	logic [32:0] sum;

	assign step_set = (ctl.op == dltq_pkg::OP_STEP_SET);
	assign step_rem = (ctl.op == dltq_pkg::OP_STEP_REM);
	assign swap = has_right && carry_q &&
		(step_rem || (step_set && right_ent.valid && right_ent.delta <= ent_q.delta));
	assign stop = step_set && carry_q && !swap;
	assign sum = {1'b0, right_ent.delta} + {1'b0, ent_q.delta};

	always_comb begin
		ent_d = ent_q;
		carry_d = carry_q;
		hit_d = hit_q;
		case (ctl.op)
			dltq_pkg::OP_TICK: begin
				if (!has_left && ent_q.delta != 32'd0) ent_d.delta = ent_q.delta - 32'd1;
			end
			dltq_pkg::OP_MATCH: hit_d = ent_q.valid && (ent_q.ident == ctl.key);
			dltq_pkg::OP_MATCH_CARRY: carry_d = ent_q.valid && (ent_q.ident == ctl.key);
			dltq_pkg::OP_CARRY_HEAD: carry_d = !has_left;
			dltq_pkg::OP_PROP: hit_d = hit_q | left_hit;
			dltq_pkg::OP_SHIFT_IN: begin
				ent_d = left_ent;
				carry_d = !has_left;
			end
			dltq_pkg::OP_STEP_SET, dltq_pkg::OP_STEP_REM: begin
				if (swap) begin
					ent_d = right_ent;
					carry_d = 1'b0;
					if (step_rem && ctl.fresh)
						ent_d.delta = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end else if (left_swap) begin
					ent_d = left_ent;
					carry_d = 1'b1;
					if (step_set) ent_d.delta = left_ent.delta - ent_q.delta;
				end else if (left_stop) begin
					if (ent_q.valid) ent_d.delta = ent_q.delta - left_ent.delta;
				end else if (stop) begin
					carry_d = 1'b0;
				end
			end
			dltq_pkg::OP_CLEAR_LAST: begin
				if (!has_right) begin
					ent_d.valid = 1'b0;
					carry_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			carry_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			ent_q <= ent_d;
			carry_q <= carry_d;
			hit_q <= hit_d;
		end
	end

	assign ent = ent_q;
	assign carry = carry_q;
	assign hit = hit_q;

endmodule

[design/delta_list_timer_queue.sv]
// Delta list timer queue: sequencer and a chain of CAP cells kept in expiry order.
// Depends on dltq_pkg and dltq_cell.
// Sequence: tick, unknown commands and rejected poll/pop go from dispatch to the result;
// cancel, poll, pop and rejected set walk the chain; an accepted set does a duplicate scan
// then insertion, one cell per cycle along the chain. One request at a time: the next one is
// taken the cycle after the result is registered; a stalled result holds the next one back.
// Reset: asynchronous, empty queue, automatic id starts at one, no clearing pass.
module delta_list_timer_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] timer_id,
	input  logic [31:0] interval,
	input  logic [31:0] arg_one,
	input  logic [31:0] arg_two,
	input  logic [63:0] context_one,
	input  logic [63:0] context_two,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] result_id,
	output logic [31:0] result_arg_one,
	output logic [31:0] result_arg_two,
	output logic [63:0] result_context_one,
	output logic [63:0] result_context_two,
	output logic [8:0]  pending_count
);

	localparam int CAP = dltq_pkg::CAP;

	typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_DUPSCAN, S_STEP, S_TAKE, S_DONE} state_t;

	state_t state_q;
	logic [2:0] cmd_q;
	logic [31:0] id_q, iv_q, h1_q, h2_q;
	logic [63:0] u1_q, u2_q;
	logic [dltq_pkg::CNT_W-1:0] live_q;
	logic [31:0] auto_q;
	logic [dltq_pkg::STEP_W-1:0] cnt_q;
	logic rem_q, fresh_q;
	logic [2:0] rs_status_q;
	logic [31:0] rs_id_q, rs_h1_q, rs_h2_q;
	logic [63:0] rs_u1_q, rs_u2_q;
	logic out_valid_q;
	logic [2:0] o_status_q;
	logic [31:0] o_id_q, o_h1_q, o_h2_q;
	logic [63:0] o_u1_q, o_u2_q;
	logic [8:0] o_cnt_q;

	dltq_pkg::cell_ctl_t ctl;
	dltq_pkg::entry_t new_ent;
	dltq_pkg::entry_t ents [CAP];
	logic [CAP-1:0] carry_v, hit_v, swap_v, stop_v, valid_v;
	logic [31:0] id_res;

	assign id_res = (id_q == 32'd0) ? auto_q : id_q;
	assign new_ent = '{valid: 1'b1, ident: id_q, delta: iv_q, h1: h1_q, h2: h2_q,
		u1: u1_q, u2: u2_q};

	genvar g;
	generate
		for (g = 0; g < CAP; g++) begin : g_cell
			dltq_pkg::entry_t l_ent, r_ent;
			logic l_swap, l_stop, l_hit;
			if (g == 0) begin : g_first
				assign l_ent = new_ent;
				assign l_swap = 1'b0;
				assign l_stop = 1'b0;
				assign l_hit = 1'b0;
			end else begin : g_mid
				assign l_ent = ents[g-1];
				assign l_swap = swap_v[g-1];
				assign l_stop = stop_v[g-1];
				assign l_hit = hit_v[g-1];
			end
			if (g == CAP - 1) begin : g_last
				assign r_ent = '0;
			end else begin : g_inner
				assign r_ent = ents[g+1];
			end
			dltq_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.has_left(g != 0), .has_right(g != CAP - 1),
				.left_ent(l_ent), .right_ent(r_ent),
				.left_swap(l_swap), .left_stop(l_stop), .left_hit(l_hit),
				.ent(ents[g]), .carry(carry_v[g]), .hit(hit_v[g]),
				.swap(swap_v[g]), .stop(stop_v[g])
			);
			assign valid_v[g] = ents[g].valid;
		end
	endgenerate

	always_comb begin
		ctl.op = dltq_pkg::OP_NONE;
		ctl.key = id_q;
		ctl.fresh = fresh_q;
		case (state_q)
			S_DISPATCH: begin
				case (cmd_q)
					dltq_pkg::CMD_TICK:
						if (live_q != '0) ctl.op = dltq_pkg::OP_TICK;
					dltq_pkg::CMD_SET: begin
						ctl.op = dltq_pkg::OP_MATCH;
						ctl.key = id_res;
					end
					dltq_pkg::CMD_CANCEL: ctl.op = dltq_pkg::OP_MATCH_CARRY;
					dltq_pkg::CMD_POLL:
						if (live_q != '0 && ents[0].delta == 32'd0)
							ctl.op = dltq_pkg::OP_CARRY_HEAD;
					dltq_pkg::CMD_POP:
						if (live_q != '0) ctl.op = dltq_pkg::OP_CARRY_HEAD;
					default: ;
				endcase
			end
			S_DUPSCAN: begin
				if (cnt_q != dltq_pkg::STEP_W'(CAP - 1))
					ctl.op = dltq_pkg::OP_PROP;
				else if (!hit_v[CAP-1] && live_q != dltq_pkg::CNT_W'(CAP))
					ctl.op = dltq_pkg::OP_SHIFT_IN;
			end
			S_STEP: ctl.op = rem_q ? dltq_pkg::OP_STEP_REM : dltq_pkg::OP_STEP_SET;
			S_TAKE: if (carry_v[CAP-1]) ctl.op = dltq_pkg::OP_CLEAR_LAST;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_q <= '0;
			auto_q <= 32'd1;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= 1'b0;
			fresh_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						id_q <= timer_id;
						iv_q <= interval;
						h1_q <= arg_one;
						h2_q <= arg_two;
						u1_q <= context_one;
						u2_q <= context_two;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					rs_status_q <= dltq_pkg::ST_OK;
					rs_id_q <= '0;
					rs_h1_q <= '0;
					rs_h2_q <= '0;
					rs_u1_q <= '0;
					rs_u2_q <= '0;
					cnt_q <= '0;
					state_q <= S_DONE;
					case (cmd_q)
						dltq_pkg::CMD_TICK:
							if (live_q == '0) rs_status_q <= dltq_pkg::ST_EMPTY;
						dltq_pkg::CMD_SET: begin
							id_q <= id_res;
							rs_id_q <= id_res;
							if (id_q == 32'd0)
								auto_q <= (auto_q == 32'hFFFF_FFFF) ? 32'd1 : auto_q + 32'd1;
							state_q <= S_DUPSCAN;
						end
						dltq_pkg::CMD_CANCEL: begin
							rem_q <= 1'b1;
							fresh_q <= 1'b1;
							state_q <= S_STEP;
						end
						dltq_pkg::CMD_POLL, dltq_pkg::CMD_POP: begin
							if (live_q == '0 ||
								(cmd_q == dltq_pkg::CMD_POLL && ents[0].delta != 32'd0)) begin
								rs_status_q <= dltq_pkg::ST_EMPTY;
							end else begin
								rem_q <= 1'b1;
								fresh_q <= 1'b0;
								state_q <= S_STEP;
							end
						end
						default: ;
					endcase
				end
				S_DUPSCAN: begin
					if (cnt_q == dltq_pkg::STEP_W'(CAP - 1)) begin
						cnt_q <= '0;
						if (hit_v[CAP-1]) begin
							rs_status_q <= dltq_pkg::ST_DUP;
							state_q <= S_DONE;
						end else if (live_q == dltq_pkg::CNT_W'(CAP)) begin
							rs_status_q <= dltq_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							rem_q <= 1'b0;
							fresh_q <= 1'b0;
							state_q <= S_STEP;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_STEP: begin
					fresh_q <= 1'b0;
					if (cnt_q == dltq_pkg::STEP_W'(CAP - 2)) begin
						if (rem_q) begin
							state_q <= S_TAKE;
						end else begin
							live_q <= live_q + 1'b1;
							state_q <= S_DONE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TAKE: begin
					if (carry_v[CAP-1]) begin
						rs_id_q <= ents[CAP-1].ident;
						rs_h1_q <= ents[CAP-1].h1;
						rs_h2_q <= ents[CAP-1].h2;
						rs_u1_q <= ents[CAP-1].u1;
						rs_u2_q <= ents[CAP-1].u2;
						live_q <= live_q - 1'b1;
					end else begin
						rs_status_q <= dltq_pkg::ST_NOTFOUND;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						o_status_q <= rs_status_q;
						o_id_q <= rs_id_q;
						o_h1_q <= rs_h1_q;
						o_h2_q <= rs_h2_q;
						o_u1_q <= rs_u1_q;
						o_u2_q <= rs_u2_q;
						o_cnt_q <= 9'(live_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status = o_status_q;
	assign result_id = o_id_q;
	assign result_arg_one = o_h1_q;
	assign result_arg_two = o_h2_q;
	assign result_context_one = o_u1_q;
	assign result_context_two = o_u2_q;
	assign pending_count = o_cnt_q;

	a_one_carrier: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(carry_v) <= 1) else $error("more than one carried entry");

	a_live_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(valid_v) == int'(live_q)))
		else $error("pending count out of step with the chain");

	a_insert_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && !rem_q) |-> (live_q != dltq_pkg::CNT_W'(CAP)))
		else $error("insertion into a full chain");

endmodule

[bench/timer_queue_checker.sv]
`timescale 1ns / 1ps
// Checker for delta_list_timer_queue: watches both channels, keeps a behavioral
// delta-list model, and compares every response. Depends on dltq_pkg.
module timer_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] timer_id,
	input  logic [31:0] interval,
	input  logic [31:0] arg_one,
	input  logic [31:0] arg_two,
	input  logic [63:0] context_one,
	input  logic [63:0] context_two,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [31:0] result_id,
	input  logic [31:0] result_arg_one,
	input  logic [31:0] result_arg_two,
	input  logic [63:0] result_context_one,
	input  logic [63:0] result_context_two,
	input  logic [8:0]  pending_count,
	output int          fail_count,
	output int          pending_responses,
	output int          pending_timers
);

	typedef struct {
		logic [31:0] ident;
		logic [31:0] delta;
		logic [31:0] h1;
		logic [31:0] h2;
		logic [63:0] u1;
		logic [63:0] u2;
	} timer_t;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] id;
		logic [31:0] h1;
		logic [31:0] h2;
		logic [63:0] u1;
		logic [63:0] u2;
		logic [8:0]  count;
	} response_t;

	timer_t     timer_list[$];
	response_t  expected_responses[$];
	logic [31:0] next_auto_id;

	assign pending_responses = expected_responses.size();
	assign pending_timers = timer_list.size();

	function automatic response_t apply_request(logic [2:0] cmd, logic [31:0] id,
			logic [31:0] iv, logic [31:0] a1, logic [31:0] a2,
			logic [63:0] c1, logic [63:0] c2);
		response_t r;
		timer_t t;
		int pos;
		logic [32:0] sum;
		r = '{default: '0};
		pos = -1;
		case (cmd)
			dltq_pkg::CMD_TICK: begin
				if (timer_list.size() == 0) r.status = dltq_pkg::ST_EMPTY;
				else if (timer_list[0].delta != 0) timer_list[0].delta--;
			end
			dltq_pkg::CMD_SET: begin
				if (id == 0) begin
					id = next_auto_id;
					next_auto_id++;
					if (next_auto_id == 0) next_auto_id = 1;
				end
				r.id = id;
				foreach (timer_list[i]) if (timer_list[i].ident == id) pos = i;
				if (pos >= 0) r.status = dltq_pkg::ST_DUP;
				else if (timer_list.size() >= dltq_pkg::CAP) r.status = dltq_pkg::ST_FULL;
				else begin
					t = '{id, iv, a1, a2, c1, c2};
					pos = timer_list.size();
					foreach (timer_list[i]) begin
						if (pos == timer_list.size()) begin
							if (timer_list[i].delta > t.delta) begin
								timer_list[i].delta -= t.delta;
								pos = i;
							end else t.delta -= timer_list[i].delta;
						end
					end
					timer_list.insert(pos, t);
				end
			end
			dltq_pkg::CMD_CANCEL: begin
				foreach (timer_list[i]) if (pos < 0 && timer_list[i].ident == id) pos = i;
				if (pos < 0) r.status = dltq_pkg::ST_NOTFOUND;
				else begin
					t = timer_list[pos];
					if (pos + 1 < timer_list.size()) begin
						sum = timer_list[pos + 1].delta + t.delta;
						timer_list[pos + 1].delta = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					end
					timer_list.delete(pos);
					r = '{dltq_pkg::ST_OK, t.ident, t.h1, t.h2, t.u1, t.u2, 9'd0};
				end
			end
			dltq_pkg::CMD_POLL, dltq_pkg::CMD_POP: begin
				if (timer_list.size() == 0 ||
						(cmd == dltq_pkg::CMD_POLL && timer_list[0].delta != 0))
					r.status = dltq_pkg::ST_EMPTY;
				else begin
					t = timer_list.pop_front();
					r = '{dltq_pkg::ST_OK, t.ident, t.h1, t.h2, t.u1, t.u2, 9'd0};
				end
			end
			default: ;
		endcase
		r.count = 9'(timer_list.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		response_t e;
		if (!arst_n) begin
			fail_count <= 0;
			timer_list.delete();
			expected_responses.delete();
			next_auto_id = 32'd1;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_responses.size() == 0) begin
					$error("unexpected response");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_responses.pop_front();
					if (status !== e.status || result_id !== e.id ||
							result_arg_one !== e.h1 || result_arg_two !== e.h2 ||
							result_context_one !== e.u1 || result_context_two !== e.u2 ||
							pending_count !== e.count)
						fail_count <= fail_count + 1;
					if (status !== e.status)
						$error("status: expected %0d, got %0d", e.status, status);
					if (result_id !== e.id)
						$error("result_id: expected %0h, got %0h", e.id, result_id);
					if (result_arg_one !== e.h1)
						$error("result_arg_one: expected %0h, got %0h", e.h1, result_arg_one);
					if (result_arg_two !== e.h2)
						$error("result_arg_two: expected %0h, got %0h", e.h2, result_arg_two);
					if (result_context_one !== e.u1)
						$error("result_context_one: expected %0h, got %0h", e.u1,
							result_context_one);
					if (result_context_two !== e.u2)
						$error("result_context_two: expected %0h, got %0h", e.u2,
							result_context_two);
					if (pending_count !== e.count)
						$error("pending_count: expected %0d, got %0d", e.count, pending_count);
				end
			end
			if (in_valid && !in_stall)
				expected_responses.push_back(apply_request(command, timer_id, interval,
					arg_one, arg_two, context_one, context_two));
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the delta_list_timer_queue bench: clock, reset, request stimulus and
// verdict. Depends on dltq_pkg, delta_list_timer_queue and timer_queue_checker.
module testbench;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  command;
	logic [31:0] timer_id;
	logic [31:0] interval;
	logic [31:0] arg_one;
	logic [31:0] arg_two;
	logic [63:0] context_one;
	logic [63:0] context_two;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] result_id;
	logic [31:0] result_arg_one;
	logic [31:0] result_arg_two;
	logic [63:0] result_context_one;
	logic [63:0] result_context_two;
	logic [8:0]  pending_count;
	int          fail_count;
	int          pending_responses;
	int          pending_timers;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          idle_cycles = 0;
	int          request_total;
	logic [31:0] recent_ids[$];

	delta_list_timer_queue u_dut (.*);
	timer_queue_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_request(logic [2:0] cmd, logic [31:0] id, logic [31:0] iv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		timer_id <= id;
		interval <= iv;
		arg_one <= $urandom;
		arg_two <= $urandom;
		context_one <= {$urandom, $urandom};
		context_two <= {$urandom, $urandom};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		request_total++;
		if (cmd == dltq_pkg::CMD_SET && id != 0) begin
			recent_ids.push_back(id);
			if (recent_ids.size() > 40) void'(recent_ids.pop_front());
		end
	endtask

	function automatic logic [31:0] pick_id();
		int k;
		k = $urandom_range(9);
		if (k < 6 && recent_ids.size() > 0)
			return recent_ids[$urandom_range(recent_ids.size() - 1)];
		if (k < 8) return $urandom_range(1, 60);
		if (k == 8) return 0;
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_interval();
		case ($urandom_range(9))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	task automatic random_phase(int n);
		int k;
		repeat (n) begin
			k = $urandom_range(99);
			if (k < 30) send_request(dltq_pkg::CMD_SET, pick_id(), pick_interval());
			else if (k < 50) send_request(dltq_pkg::CMD_TICK, $urandom, $urandom);
			else if (k < 62) send_request(dltq_pkg::CMD_CANCEL, pick_id(), $urandom);
			else if (k < 80) send_request(dltq_pkg::CMD_POLL, $urandom, $urandom);
			else if (k < 95) send_request(dltq_pkg::CMD_POP, $urandom, $urandom);
			else send_request(3'($urandom_range(5, 7)), $urandom, $urandom);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		command = dltq_pkg::CMD_TICK;
		timer_id = '0;
		interval = '0;
		arg_one = '0;
		arg_two = '0;
		context_one = '0;
		context_two = '0;
		request_total = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, auto ids, ties, duplicates, saturation
		send_request(dltq_pkg::CMD_TICK, 0, 0);
		send_request(dltq_pkg::CMD_POLL, 0, 0);
		send_request(dltq_pkg::CMD_POP, 0, 0);
		send_request(dltq_pkg::CMD_CANCEL, 0, 0);
		send_request(dltq_pkg::CMD_SET, 0, 5);
		send_request(dltq_pkg::CMD_SET, 0, 5);
		send_request(dltq_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(dltq_pkg::CMD_SET, 32'hFFFF_FFFF, 3);
		send_request(dltq_pkg::CMD_SET, 7, 0);
		send_request(dltq_pkg::CMD_SET, 8, 2);
		send_request(dltq_pkg::CMD_CANCEL, 8, 0);
		send_request(dltq_pkg::CMD_SET, 9, 32'hFFFF_FFF0);
		send_request(dltq_pkg::CMD_CANCEL, 9, 0);
		send_request(dltq_pkg::CMD_POLL, 0, 0);
		send_request(dltq_pkg::CMD_POLL, 0, 0);
		send_request(dltq_pkg::CMD_TICK, 0, 0);
		send_request(dltq_pkg::CMD_POP, 0, 0);
		send_request(3'd5, 1, 1);
		send_request(3'd7, 1, 1);
		send_request(dltq_pkg::CMD_CANCEL, 32'h1234_5678, 0);
		send_request(dltq_pkg::CMD_POP, 0, 0);
		send_request(dltq_pkg::CMD_POP, 0, 0);
		send_request(dltq_pkg::CMD_POP, 0, 0);

		// fill to capacity once, then overflow
		repeat (dltq_pkg::CAP) send_request(dltq_pkg::CMD_SET, 0, $urandom_range(0, 300));
		send_request(dltq_pkg::CMD_SET, 0, 1);
		send_request(dltq_pkg::CMD_SET, 1, 1);
		repeat (dltq_pkg::CAP - 40) send_request(dltq_pkg::CMD_POP, 0, 0);

		send_idle_pct = 9;
		recv_idle_pct = 73;
		random_phase(120);
		send_idle_pct = 73;
		recv_idle_pct = 9;
		random_phase(120);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(120);
		in_valid <= 1'b0;

		while (pending_responses != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran %0d requests over all commands, including a full queue and overflow.",
			request_total);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
